// File: hdl/jmbq_pkg.sv
`timescale 1ns / 1ps

package jmbq_pkg;

    // Number of debounced buttons: the stick button first, then four keys.
    localparam int NUM_BTN   = 5;
    localparam int BTN_IDX_W = $clog2(NUM_BTN);

    // Field widths of one poll and one result.
    localparam int TIME_W   = 32;
    localparam int SAMPLE_W = 12;
    localparam int KEYS_W   = 4;
    localparam int MOVE_W   = 8;
    localparam int SPEED_W  = 7;
    localparam int DZ_W     = 11;
    localparam int MS_W     = 16;
    localparam int CLICK_W  = 2;

    // Scaled numerator (|d| - deadzone) * top speed fits in this many bits.
    localparam int NUM_W = SAMPLE_W + SPEED_W;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 32;

    // Input tdata bit positions, lowest field first.
    localparam int IN_NOW_LSB   = 0;
    localparam int IN_SX_LSB    = IN_NOW_LSB + TIME_W;
    localparam int IN_SY_LSB    = IN_SX_LSB + SAMPLE_W;
    localparam int IN_STICK_LSB = IN_SY_LSB + SAMPLE_W;
    localparam int IN_KEYS_LSB  = IN_STICK_LSB + 1;
    localparam int IN_USED_W    = IN_KEYS_LSB + KEYS_W;

    // Output tdata bit positions, lowest field first.
    localparam int OUT_MX_LSB    = 0;
    localparam int OUT_MY_LSB    = OUT_MX_LSB + MOVE_W;
    localparam int OUT_MV_LSB    = OUT_MY_LSB + MOVE_W;
    localparam int OUT_CLICK_LSB = OUT_MV_LSB + 1;
    localparam int OUT_DOWN_LSB  = OUT_CLICK_LSB + CLICK_W;
    localparam int OUT_UP_LSB    = OUT_DOWN_LSB + KEYS_W;
    localparam int OUT_USED_W    = OUT_UP_LSB + KEYS_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_SPEED  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 3'd5;

    localparam logic [SAMPLE_W-1:0] RST_CENTER     = 12'd2048;
    localparam logic [DZ_W-1:0]     RST_DEADZONE   = 11'd50;
    localparam logic [SPEED_W-1:0]  RST_TOP_SPEED  = 7'd10;
    localparam logic [MS_W-1:0]     RST_DEBOUNCE   = 16'd30;
    localparam logic [MS_W-1:0]     RST_LONG_PRESS = 16'd1000;

    // Full-scale axis offset used as the top of the scaling range.
    localparam logic [SAMPLE_W-1:0] AXIS_FULL_SCALE = 12'd2048;

    localparam logic [CLICK_W-1:0] CLICKS_PRESS = 2'd1;
    localparam logic [CLICK_W-1:0] CLICKS_LONG  = 2'd2;

endpackage

// File: hdl/joystick_mouse_button_qualifier_unit.sv
`timescale 1ns / 1ps

// Joystick to mouse poll qualifier.
// A poll enters on the s_axis channel: one transaction carries the millisecond
// timestamp, the X and Y joystick samples and the five raw button levels.
// Each poll yields exactly one result on the m_axis channel: the negated,
// dead-zoned and scaled motion steps, a motion flag, the stick click count and
// the debounced key down and up events.
// Registers are written through the plain write port (index, data, enable);
// the user must write them only while no poll is in flight; the block does not enforce it.
// The sequencer walks the five buttons through one shared 32-bit time
// subtractor (one button per cycle, then the long-press test), then runs
// each axis through one shared restoring divider, one quotient bit per cycle.
// A new poll is accepted only after the previous one has been handed to the
// output register.
// The result sits in an output register; while the receiver stalls the block
// still accepts and works on the next poll and only waits at its end until
// the output register is free.
// Reset (synchronous, active low) restores the register defaults, marks all
// buttons as raw and debounced pressed, clears all button timestamps and empties the
// output register.
module joystick_mouse_button_qualifier_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // now_ms, sample_x, sample_y, stick_pressed, keys_pressed, zero fill
    input  logic [jmbq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // move_x, move_y, move_valid, click_count, key_down_events,
    // key_up_events, zero fill
    output logic [jmbq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [jmbq_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [jmbq_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int NB  = jmbq_pkg::NUM_BTN;
    localparam int BW  = jmbq_pkg::BTN_IDX_W;
    localparam int TW  = jmbq_pkg::TIME_W;
    localparam int SW  = jmbq_pkg::SAMPLE_W;
    localparam int KW  = jmbq_pkg::KEYS_W;
    localparam int MW  = jmbq_pkg::MOVE_W;
    localparam int PW  = jmbq_pkg::SPEED_W;
    localparam int DW  = jmbq_pkg::DZ_W;
    localparam int HW  = jmbq_pkg::MS_W;
    localparam int CW  = jmbq_pkg::CLICK_W;
    localparam int QW  = jmbq_pkg::NUM_W;
    localparam int CNW = $clog2(QW);

    localparam logic [BW-1:0]  LAST_BTN = BW'(NB - 1);
    localparam logic [CNW-1:0] LAST_DIV = CNW'(QW - 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_BTN   = 8'b0000_0010,
        S_LONG  = 8'b0000_0100,
        S_MUL_X = 8'b0000_1000,
        S_DIV_X = 8'b0001_0000,
        S_MUL_Y = 8'b0010_0000,
        S_DIV_Y = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [SW-1:0] r_center_x, r_center_y;
    logic [DW-1:0] r_deadzone;
    logic [PW-1:0] r_top_speed;
    logic [HW-1:0] r_debounce_ms, r_long_press_ms;

    // Latched poll.
    logic [TW-1:0] r_now;
    logic [SW-1:0] r_sx, r_sy;
    logic [NB-1:0] r_raw;

    // Button state; index 0 is the stick, 1 to 4 the keys.
    logic [NB-1:0] r_raw_last;
    logic [NB-1:0] r_stable;
    logic [TW-1:0] r_change_time [NB];
    logic [TW-1:0] r_press_start;
    logic          r_long_done;
    logic          r_press_valid;
    logic          r_accepted_now;
    logic [BW-1:0] r_btn;

    // Working result.
    logic [CW-1:0] r_clicks;
    logic [KW-1:0] r_downs, r_ups;
    logic [MW-1:0] r_mx;

    // Shared divider.
    logic [QW-1:0]  r_dq, n_dq;
    logic [DW-1:0]  r_rem, n_rem;
    logic [CNW-1:0] r_cnt;
    logic           r_neg;

    // Output register.
    logic                            r_out_valid;
    logic [jmbq_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic w_in_acc;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---------------- shared time subtractor ----------------
    logic          w_raw, w_changed, w_btn_acc, w_long_hit;
    logic [TW-1:0] w_sub_b, w_diff, w_thr;

    always_comb begin
        w_raw     = r_raw[r_btn];
        w_changed = (w_raw != r_raw_last[r_btn]);
        w_sub_b   = (r_state == S_LONG) ? r_press_start : r_change_time[r_btn];
        w_thr     = (r_state == S_LONG) ? TW'(r_long_press_ms) : TW'(r_debounce_ms);
        w_diff    = r_now - w_sub_b;
        w_btn_acc = !w_changed && (w_diff > w_thr) && (r_stable[r_btn] != w_raw);
        w_long_hit = !r_accepted_now && r_stable[0] && r_press_valid && !r_long_done &&
                     !(w_thr > w_diff);
    end

    // ---------------- axis numerator ----------------
    logic [SW-1:0] w_sample, w_center, w_mag, w_excess;
    logic [SW:0]   w_d;
    logic          w_d_neg;
    logic [QW-1:0] w_num;
    logic [SW-1:0] w_divisor;

    always_comb begin
        w_sample  = (r_state == S_MUL_Y) ? r_sy : r_sx;
        w_center  = (r_state == S_MUL_Y) ? r_center_y : r_center_x;
        w_d       = {1'b0, w_sample} - {1'b0, w_center};
        w_d_neg   = w_d[SW];
        w_mag     = w_d_neg ? SW'(-w_d) : w_d[SW-1:0];
        w_excess  = w_mag - SW'(r_deadzone);
        if (w_mag > SW'(r_deadzone)) begin
            w_num = QW'(w_excess) * QW'(r_top_speed);
        end else begin
            w_num = '0;
        end
        w_divisor = jmbq_pkg::AXIS_FULL_SCALE - SW'(r_deadzone);
    end

    // ---------------- restoring divider step ----------------
    logic [SW-1:0] w_trial;
    logic          w_ge;

    always_comb begin
        w_trial = {r_rem, r_dq[QW-1]};
        w_ge    = (w_trial >= w_divisor);
        n_rem   = w_ge ? DW'(w_trial - w_divisor) : w_trial[DW-1:0];
        n_dq    = {r_dq[QW-2:0], w_ge};
    end

    // Clamp the finished quotient and apply the reporting sign.
    logic [PW-1:0] w_qmag;
    logic [MW-1:0] w_move;

    always_comb begin
        w_qmag = (r_dq > QW'(r_top_speed)) ? r_top_speed : r_dq[PW-1:0];
        w_move = r_neg ? {1'b0, w_qmag} : MW'(-{1'b0, w_qmag});
    end

    // ---------------- sequencer ----------------
    logic w_out_free;
    assign w_out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_BTN;
            S_BTN:   if (r_btn == LAST_BTN) n_state = S_LONG;
            S_LONG:  n_state = S_MUL_X;
            S_MUL_X: n_state = S_DIV_X;
            S_DIV_X: if (r_cnt == LAST_DIV) n_state = S_MUL_Y;
            S_MUL_Y: n_state = S_DIV_Y;
            S_DIV_Y: if (r_cnt == LAST_DIV) n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x      <= jmbq_pkg::RST_CENTER;
            r_center_y      <= jmbq_pkg::RST_CENTER;
            r_deadzone      <= jmbq_pkg::RST_DEADZONE;
            r_top_speed     <= jmbq_pkg::RST_TOP_SPEED;
            r_debounce_ms   <= jmbq_pkg::RST_DEBOUNCE;
            r_long_press_ms <= jmbq_pkg::RST_LONG_PRESS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                jmbq_pkg::CFG_CENTER_X:   r_center_x      <= i_cfg_wdata[SW-1:0];
                jmbq_pkg::CFG_CENTER_Y:   r_center_y      <= i_cfg_wdata[SW-1:0];
                jmbq_pkg::CFG_DEADZONE:   r_deadzone      <= i_cfg_wdata[DW-1:0];
                jmbq_pkg::CFG_TOP_SPEED:  r_top_speed     <= i_cfg_wdata[PW-1:0];
                jmbq_pkg::CFG_DEBOUNCE:   r_debounce_ms   <= i_cfg_wdata[HW-1:0];
                jmbq_pkg::CFG_LONG_PRESS: r_long_press_ms <= i_cfg_wdata[HW-1:0];
                default: ;
            endcase
        end
    end

    // Poll latch (payload, no reset).
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_now <= s_axis_tdata[jmbq_pkg::IN_NOW_LSB +: TW];
            r_sx  <= s_axis_tdata[jmbq_pkg::IN_SX_LSB +: SW];
            r_sy  <= s_axis_tdata[jmbq_pkg::IN_SY_LSB +: SW];
            r_raw <= {s_axis_tdata[jmbq_pkg::IN_KEYS_LSB +: KW],
                      s_axis_tdata[jmbq_pkg::IN_STICK_LSB]};
        end
    end

    // Button walk and long-press test.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_last     <= '1;
            r_stable       <= '1;
            for (int i = 0; i < NB; i++) begin
                r_change_time[i] <= '0;
            end
            r_press_start  <= '0;
            r_long_done    <= 1'b0;
            r_press_valid  <= 1'b0;
            r_accepted_now <= 1'b0;
            r_btn          <= '0;
            r_clicks       <= '0;
            r_downs        <= '0;
            r_ups          <= '0;
        end else if (w_in_acc) begin
            r_btn          <= '0;
            r_accepted_now <= 1'b0;
            r_clicks       <= '0;
            r_downs        <= '0;
            r_ups          <= '0;
        end else if (r_state == S_BTN) begin
            r_btn <= r_btn + 1'b1;
            if (w_changed) begin
                r_raw_last[r_btn]    <= w_raw;
                r_change_time[r_btn] <= r_now;
            end
            if (w_btn_acc) begin
                r_stable[r_btn] <= w_raw;
            end
            if (r_btn == '0) begin
                if (w_btn_acc) begin
                    r_long_done <= 1'b0;
                    if (w_raw) begin
                        r_press_start  <= r_now;
                        r_press_valid  <= 1'b1;
                        r_clicks       <= jmbq_pkg::CLICKS_PRESS;
                        r_accepted_now <= 1'b1;
                    end else begin
                        r_press_start <= '0;
                        r_press_valid <= 1'b0;
                    end
                end
            end else begin
                // Keys arrive in bit order, so shifting in from the top
                // leaves key k in bit k after the fourth key.
                r_downs <= {w_btn_acc && w_raw, r_downs[KW-1:1]};
                r_ups   <= {w_btn_acc && !w_raw, r_ups[KW-1:1]};
            end
        end else if (r_state == S_LONG) begin
            if (w_long_hit) begin
                r_long_done <= 1'b1;
                r_clicks    <= r_clicks + jmbq_pkg::CLICKS_LONG;
            end
        end
    end

    // Axis scaling through the shared divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_state == S_MUL_X || r_state == S_MUL_Y) begin
            r_cnt <= '0;
        end else if (r_state == S_DIV_X || r_state == S_DIV_Y) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL_X || r_state == S_MUL_Y) begin
            r_dq  <= w_num;
            r_rem <= '0;
            r_neg <= w_d_neg;
        end else if (r_state == S_DIV_X || r_state == S_DIV_Y) begin
            r_dq  <= n_dq;
            r_rem <= n_rem;
        end
        // The X quotient is finished when the Y axis is set up.
        if (r_state == S_MUL_Y) begin
            r_mx <= w_move;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_data <= {(jmbq_pkg::OUT_TDATA_W - jmbq_pkg::OUT_USED_W)'(0),
                           r_ups, r_downs, r_clicks,
                           (r_mx != '0) || (w_move != '0),
                           w_move, r_mx};
        end
    end

endmodule

// File: hdl/jmbq_checker.sv
`timescale 1ns / 1ps

module jmbq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [jmbq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int MW = jmbq_pkg::MOVE_W;
    localparam int KW = jmbq_pkg::KEYS_W;
    localparam int CW = jmbq_pkg::CLICK_W;

    logic [MW-1:0] w_mx, w_my;
    logic [KW-1:0] w_down, w_up;
    logic [CW-1:0] w_click;
    logic          w_mv;

    assign w_mx    = m_axis_tdata[jmbq_pkg::OUT_MX_LSB +: MW];
    assign w_my    = m_axis_tdata[jmbq_pkg::OUT_MY_LSB +: MW];
    assign w_mv    = m_axis_tdata[jmbq_pkg::OUT_MV_LSB];
    assign w_click = m_axis_tdata[jmbq_pkg::OUT_CLICK_LSB +: CW];
    assign w_down  = m_axis_tdata[jmbq_pkg::OUT_DOWN_LSB +: KW];
    assign w_up    = m_axis_tdata[jmbq_pkg::OUT_UP_LSB +: KW];

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // One poll at a time: the block is busy right after taking one.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("poll accepted while the previous one is in flight");

    a_move_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_mv == ((w_mx != '0) || (w_my != '0))))
        else $error("move_valid disagrees with the motion steps");

    // Steps are clamped to +/-127 and at most two clicks come per poll.
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_mx != 8'h80) && (w_my != 8'h80) && (w_click != 2'd3))
        else $error("motion step or click count out of range");

    a_key_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((w_down & w_up) == '0))
        else $error("key reported both pressed and released");

endmodule

bind joystick_mouse_button_qualifier_unit jmbq_checker u_jmbq_checker (.*);

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic [jmbq_pkg::TIME_W-1:0]   now;
        logic [jmbq_pkg::SAMPLE_W-1:0] sx;
        logic [jmbq_pkg::SAMPLE_W-1:0] sy;
        logic                          stick;
        logic [jmbq_pkg::KEYS_W-1:0]   keys;
    } t_poll;

    typedef struct {
        logic signed [jmbq_pkg::MOVE_W-1:0] mx;
        logic signed [jmbq_pkg::MOVE_W-1:0] my;
        logic                               mv;
        logic [jmbq_pkg::CLICK_W-1:0]       clicks;
        logic [jmbq_pkg::KEYS_W-1:0]        downs;
        logic [jmbq_pkg::KEYS_W-1:0]        ups;
    } t_report;

    typedef enum logic [1:0] {RX_FREE, RX_CHOPPY, RX_THROTTLED} t_rx_mode;

    logic                             i_clk;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    // now_ms, sample_x, sample_y, stick_pressed, keys_pressed, zero fill
    logic [jmbq_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    // move_x, move_y, move_valid, click_count, key_down_events,
    // key_up_events, zero fill
    logic [jmbq_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             i_cfg_we = 1'b0;
    logic [jmbq_pkg::CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [jmbq_pkg::CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    joystick_mouse_button_qualifier_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Register copies kept by the predictor.
    logic [jmbq_pkg::SAMPLE_W-1:0] cfg_cx;
    logic [jmbq_pkg::SAMPLE_W-1:0] cfg_cy;
    logic [jmbq_pkg::DZ_W-1:0]     cfg_dz;
    logic [jmbq_pkg::SPEED_W-1:0]  cfg_speed;
    logic [jmbq_pkg::MS_W-1:0]     cfg_debounce;
    logic [jmbq_pkg::MS_W-1:0]     cfg_long;

    // Button state of the predictor: index 0 is the stick, 1..4 the keys.
    logic                        btn_raw      [jmbq_pkg::NUM_BTN];
    logic [jmbq_pkg::TIME_W-1:0] btn_change_t [jmbq_pkg::NUM_BTN];
    logic                        btn_level    [jmbq_pkg::NUM_BTN];
    logic [jmbq_pkg::TIME_W-1:0] press_t;
    logic                        long_done;
    logic                        press_armed;

    t_poll   pending_polls[$];
    t_report expected_reports[$];
    int      err_count = 0;

    // Simulated user: timestamp cursor and per-button held levels.
    logic [jmbq_pkg::TIME_W-1:0] user_t = '0;
    logic                        user_level [jmbq_pkg::NUM_BTN];
    int                          user_hold  [jmbq_pkg::NUM_BTN];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int scaled_offset(int sample, int centre);
        int d, mag, q, dz, sp;
        d   = sample - centre;
        mag = (d < 0) ? -d : d;
        dz  = int'(cfg_dz);
        sp  = int'(cfg_speed);
        if (mag <= dz)
            return 0;
        q = ((mag - dz) * sp) / (2048 - dz);
        if (q > sp)
            q = sp;
        return (d < 0) ? -q : q;
    endfunction

    // Returns 1 when the accepted level of button b flips.
    function automatic bit settle_button(int b, logic [jmbq_pkg::TIME_W-1:0] now, logic raw);
        logic [jmbq_pkg::TIME_W-1:0] held;
        if (raw != btn_raw[b]) begin
            btn_change_t[b] = now;
            btn_raw[b]      = raw;
        end
        held = now - btn_change_t[b];
        if (held > {16'h0, cfg_debounce} && btn_level[b] != raw) begin
            btn_level[b] = raw;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_report qualify_poll(t_poll p);
        t_report                     r;
        int                          mx, my, k;
        bit                          just_pressed;
        logic [jmbq_pkg::TIME_W-1:0] hold_t;
        mx = -scaled_offset(p.sx, cfg_cx);
        my = -scaled_offset(p.sy, cfg_cy);
        r.clicks = '0;
        r.downs  = '0;
        r.ups    = '0;
        just_pressed = 1'b0;
        if (settle_button(0, p.now, p.stick)) begin
            if (btn_level[0]) begin
                press_t      = p.now;
                long_done    = 1'b0;
                press_armed  = 1'b1;
                r.clicks     = jmbq_pkg::CLICKS_PRESS;
                just_pressed = 1'b1;
            end else begin
                press_t     = '0;
                long_done   = 1'b0;
                press_armed = 1'b0;
            end
        end
        // The long-press test is skipped on the poll that accepts the press.
        hold_t = p.now - press_t;
        if (!just_pressed && btn_level[0] && press_armed && !long_done &&
            hold_t >= {16'h0, cfg_long}) begin
            long_done = 1'b1;
            r.clicks  = r.clicks + jmbq_pkg::CLICKS_LONG;
        end
        for (k = 0; k < jmbq_pkg::KEYS_W; k++) begin
            if (settle_button(k + 1, p.now, p.keys[k])) begin
                if (btn_level[k + 1])
                    r.downs[k] = 1'b1;
                else
                    r.ups[k] = 1'b1;
            end
        end
        r.mx = mx[jmbq_pkg::MOVE_W-1:0];
        r.my = my[jmbq_pkg::MOVE_W-1:0];
        r.mv = (mx != 0 || my != 0);
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // Driver: bursts of transactions separated by random gaps.
    t_poll                           cur_poll;
    logic [jmbq_pkg::IN_TDATA_W-1:0] tx_word;
    int                              tx_burst;
    int                              tx_gap;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            tx_burst = 1;
            tx_gap   = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_reports.push_back(qualify_poll(cur_poll));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_polls.size() > 0) begin
                    cur_poll = pending_polls.pop_front();
                    tx_word = '0;
                    tx_word[jmbq_pkg::IN_NOW_LSB +: jmbq_pkg::TIME_W]    = cur_poll.now;
                    tx_word[jmbq_pkg::IN_SX_LSB +: jmbq_pkg::SAMPLE_W]   = cur_poll.sx;
                    tx_word[jmbq_pkg::IN_SY_LSB +: jmbq_pkg::SAMPLE_W]   = cur_poll.sy;
                    tx_word[jmbq_pkg::IN_STICK_LSB]                      = cur_poll.stick;
                    tx_word[jmbq_pkg::IN_KEYS_LSB +: jmbq_pkg::KEYS_W]   = cur_poll.keys;
                    s_axis_tdata  <= tx_word;
                    s_axis_tvalid <= 1'b1;
                    if (tx_burst <= 1) begin
                        tx_burst = $urandom_range(8, 1);
                        tx_gap   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(60, 1);
                    end else begin
                        tx_burst--;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: the receiver switches between free flow, choppy stalls and
    // long stretches that hold the result register full.
    t_rx_mode rx_mode;
    int       rx_left;
    t_report  want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_mode = RX_FREE;
            rx_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_reports.size() == 0) begin
                    $error("result transaction with no poll pending: %h", m_axis_tdata);
                    err_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("move_x", want.mx,
                        $signed(m_axis_tdata[jmbq_pkg::OUT_MX_LSB +: jmbq_pkg::MOVE_W]));
                    check_field("move_y", want.my,
                        $signed(m_axis_tdata[jmbq_pkg::OUT_MY_LSB +: jmbq_pkg::MOVE_W]));
                    check_field("move_valid", want.mv, m_axis_tdata[jmbq_pkg::OUT_MV_LSB]);
                    check_field("click_count", want.clicks,
                        m_axis_tdata[jmbq_pkg::OUT_CLICK_LSB +: jmbq_pkg::CLICK_W]);
                    check_field("key_down_events", want.downs,
                        m_axis_tdata[jmbq_pkg::OUT_DOWN_LSB +: jmbq_pkg::KEYS_W]);
                    check_field("key_up_events", want.ups,
                        m_axis_tdata[jmbq_pkg::OUT_UP_LSB +: jmbq_pkg::KEYS_W]);
                end
            end
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(2, 0));
                rx_left = $urandom_range(200, 20);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_FREE:    m_axis_tready <= 1'b1;
                RX_CHOPPY:  m_axis_tready <= ($urandom_range(2, 0) != 0);
                default:    m_axis_tready <= (rx_left % 64 == 0);
            endcase
        end
    end

    task automatic push_poll(logic [jmbq_pkg::TIME_W-1:0] now, int sx, int sy, logic stick,
                             logic [jmbq_pkg::KEYS_W-1:0] keys);
        t_poll p;
        p.now   = now;
        p.sx    = sx[jmbq_pkg::SAMPLE_W-1:0];
        p.sy    = sy[jmbq_pkg::SAMPLE_W-1:0];
        p.stick = stick;
        p.keys  = keys;
        pending_polls.push_back(p);
    endtask

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pending_polls.size() != 0 || s_axis_tvalid || expected_reports.size() != 0);
    endtask

    task automatic write_reg(logic [jmbq_pkg::CFG_IDX_W-1:0] idx, int val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val[jmbq_pkg::CFG_DATA_W-1:0];
        case (idx)
            jmbq_pkg::CFG_CENTER_X:   cfg_cx       = val[jmbq_pkg::SAMPLE_W-1:0];
            jmbq_pkg::CFG_CENTER_Y:   cfg_cy       = val[jmbq_pkg::SAMPLE_W-1:0];
            jmbq_pkg::CFG_DEADZONE:   cfg_dz       = val[jmbq_pkg::DZ_W-1:0];
            jmbq_pkg::CFG_TOP_SPEED:  cfg_speed    = val[jmbq_pkg::SPEED_W-1:0];
            jmbq_pkg::CFG_DEBOUNCE:   cfg_debounce = val[jmbq_pkg::MS_W-1:0];
            jmbq_pkg::CFG_LONG_PRESS: cfg_long     = val[jmbq_pkg::MS_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly near the centre, around the dead-zone edge; sometimes anywhere.
    function automatic int pick_sample(int centre);
        int v, span;
        if ($urandom_range(3, 0) == 0)
            return $urandom_range(4095, 0);
        span = int'(cfg_dz) + 200;
        v = centre + int'($urandom_range(2 * span, 0)) - span;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v;
    endfunction

    // Held levels with occasional contact bounce and rare timestamp jumps.
    task automatic gen_polls(int n, int step_lo, int step_hi);
        int           i, b;
        logic [4:0]   raw;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(49, 0) == 0)
                user_t = $urandom();
            else
                user_t = user_t + $urandom_range(step_hi, step_lo);
            for (b = 0; b < jmbq_pkg::NUM_BTN; b++) begin
                if (user_hold[b] == 0) begin
                    user_level[b] = ~user_level[b];
                    user_hold[b]  = (b == 0) ? $urandom_range(30, 1) : $urandom_range(12, 1);
                end else begin
                    user_hold[b]--;
                end
                raw[b] = user_level[b] ^ ($urandom_range(7, 0) == 0);
            end
            push_poll(user_t, pick_sample(cfg_cx), pick_sample(cfg_cy), raw[0], raw[4:1]);
        end
    endtask

    int ph, pick;

    initial begin
        cfg_cx       = jmbq_pkg::RST_CENTER;
        cfg_cy       = jmbq_pkg::RST_CENTER;
        cfg_dz       = jmbq_pkg::RST_DEADZONE;
        cfg_speed    = jmbq_pkg::RST_TOP_SPEED;
        cfg_debounce = jmbq_pkg::RST_DEBOUNCE;
        cfg_long     = jmbq_pkg::RST_LONG_PRESS;
        for (int b = 0; b < jmbq_pkg::NUM_BTN; b++) begin
            btn_raw[b]      = 1'b1;
            btn_change_t[b] = '0;
            btn_level[b]    = 1'b1;
            user_level[b]   = 1'b1;
            user_hold[b]    = 0;
        end
        press_t     = '0;
        long_done   = 1'b0;
        press_armed = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: levels start pressed, release and press again,
        // long press, a key pressed and another released in one poll,
        // then a press and long press across the timestamp wrap.
        push_poll(32'd0, 0, 4095, 1'b1, 4'hF);
        push_poll(32'd5, 4095, 0, 1'b0, 4'h0);
        push_poll(32'd40, 4095, 0, 1'b0, 4'h0);
        push_poll(32'd41, 2098, 1997, 1'b1, 4'h5);
        push_poll(32'd72, 2099, 0, 1'b1, 4'h5);
        push_poll(32'd1072, 2048, 2048, 1'b1, 4'hA);
        push_poll(32'd1103, 2048, 2048, 1'b1, 4'hA);
        push_poll(32'd1200, 2048, 2048, 1'b0, 4'h0);
        push_poll(32'd1231, 2048, 2048, 1'b0, 4'h0);
        push_poll(32'hFFFF_FFC0, 1000, 3000, 1'b1, 4'h0);
        push_poll(32'hFFFF_FFE0, 1000, 3000, 1'b1, 4'h0);
        push_poll(32'h0000_03C8, 1000, 3000, 1'b1, 4'h0);
        push_poll(32'h0000_03C9, 1000, 3000, 1'b1, 4'h0);

        // Extreme centres, no dead zone, full speed, zero debounce and zero
        // long-press time.
        wait_idle();
        write_reg(jmbq_pkg::CFG_CENTER_X, 0);
        write_reg(jmbq_pkg::CFG_CENTER_Y, 4095);
        write_reg(jmbq_pkg::CFG_DEADZONE, 0);
        write_reg(jmbq_pkg::CFG_TOP_SPEED, 127);
        write_reg(jmbq_pkg::CFG_DEBOUNCE, 0);
        write_reg(jmbq_pkg::CFG_LONG_PRESS, 0);
        push_poll(32'd100, 4095, 0, 1'b0, 4'hF);
        push_poll(32'd101, 4095, 0, 1'b0, 4'hF);
        push_poll(32'd102, 0, 4095, 1'b1, 4'h0);
        push_poll(32'd103, 0, 4095, 1'b1, 4'h0);
        push_poll(32'd103, 2048, 2048, 1'b1, 4'h0);

        // Widest dead zone and the longest hold times.
        wait_idle();
        write_reg(jmbq_pkg::CFG_CENTER_X, 2048);
        write_reg(jmbq_pkg::CFG_CENTER_Y, 2048);
        write_reg(jmbq_pkg::CFG_DEADZONE, 2047);
        write_reg(jmbq_pkg::CFG_DEBOUNCE, 65535);
        write_reg(jmbq_pkg::CFG_LONG_PRESS, 65535);
        push_poll(32'd200, 0, 4095, 1'b0, 4'h0);
        push_poll(32'd65735, 4095, 0, 1'b0, 4'h0);
        push_poll(32'd65736, 0, 0, 1'b0, 4'h0);

        // Zero speed gives no motion at all.
        wait_idle();
        write_reg(jmbq_pkg::CFG_TOP_SPEED, 0);
        push_poll(32'd65737, 0, 4095, 1'b1, 4'hF);
        push_poll(32'd70000, 4095, 0, 1'b1, 4'hF);

        user_t = 32'd80000;
        for (ph = 0; ph < 8; ph++) begin
            wait_idle();
            pick = $urandom_range(3, 0);
            write_reg(jmbq_pkg::CFG_CENTER_X, (pick == 0) ? 0 : (pick == 1) ? 4095 :
                                              $urandom_range(2200, 1900));
            write_reg(jmbq_pkg::CFG_CENTER_Y,
                      ($urandom_range(3, 0) == 0) ? $urandom_range(4095, 0) :
                                                    $urandom_range(2200, 1900));
            pick = $urandom_range(3, 0);
            write_reg(jmbq_pkg::CFG_DEADZONE, (pick == 0) ? 0 : (pick == 1) ? 2047 :
                                              (pick == 2) ? $urandom_range(2047, 0) :
                                              $urandom_range(200, 20));
            pick = $urandom_range(4, 0);
            write_reg(jmbq_pkg::CFG_TOP_SPEED, (pick == 0) ? 0 : (pick == 1) ? 1 :
                                               (pick == 2) ? 127 : $urandom_range(127, 1));
            if ($urandom_range(2, 0) == 0)
                user_t = 32'hFFFF_FFFF - $urandom_range(500, 0);
            if (ph == 3) begin
                // Coarse timestamps against the longest hold times.
                write_reg(jmbq_pkg::CFG_DEBOUNCE, 65535);
                write_reg(jmbq_pkg::CFG_LONG_PRESS, 65535);
                gen_polls(60, 2000, 30000);
            end else begin
                pick = $urandom_range(2, 0);
                write_reg(jmbq_pkg::CFG_DEBOUNCE, (pick == 0) ? 0 : (pick == 1) ?
                                                  $urandom_range(15, 1) :
                                                  $urandom_range(60, 16));
                pick = $urandom_range(3, 0);
                write_reg(jmbq_pkg::CFG_LONG_PRESS, (pick == 0) ? 0 : (pick == 1) ? 1 :
                                                    $urandom_range(400, 2));
                gen_polls(80, 1, 20);
            end
        end

        wait_idle();
        repeat (60) @(posedge i_clk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: joystick_mouse_button_qualifier_unit.f
hdl/jmbq_pkg.sv
hdl/joystick_mouse_button_qualifier_unit.sv
hdl/jmbq_checker.sv
dv/tb_top.sv
